### sv/gms_pkg.sv
// ----------------------------------------------------------------------------
// gms_pkg: shared definitions for the grid maze set merge unit
// Field widths, function codes and configuration register indexes.
// ----------------------------------------------------------------------------
package gms_pkg;

    localparam int CFG_W  = 6;   // width of the grid_width and grid_height registers
    localparam int FUNC_W = 2;
    localparam int WALL_W = 10;  // width of wall_index

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Function codes carried on s_tuser.
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_VWALL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HWALL   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

endpackage

### sv/grid_maze_set_merge_unit.sv
// A restart relabels every cell, one label write per cycle; a wall that merges two sets
// takes a divide, two label reads and one full pass over the memory; a wall whose cells
// share a set skips the pass, a bad wall is refused after the bound test, and unused code
// goes straight to the result.
// One item is in work at a time; s_tready returns with m_tvalid, later if a result still waits.
// Reset: a pass labels each cell by its index; configuration registers reset to 32.
// ----------------------------------------------------------------------------
// grid_maze_set_merge_unit: union-find core of a Kruskal maze carver
// Decodes a wall index, compares the labels of its two cells and relabels one set.
// ----------------------------------------------------------------------------
module grid_maze_set_merge_unit
    import gms_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] wall_index, [15:10] zero
    input  logic [FUNC_W-1:0]    s_tuser,   // [1:0] func
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] opened, [1] bad_wall, [7:2] zero
);

    localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int LBL_W      = $clog2(CELL_COUNT);
    localparam int CNT_W      = LBL_W + 1;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int PROD_W     = WALL_W + SIDE_W;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_BOUND  = 4'd2;
    localparam logic [3:0] ST_TEST   = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_ADDR   = 4'd6;
    localparam logic [3:0] ST_RDA    = 4'd7;
    localparam logic [3:0] ST_RDB    = 4'd8;
    localparam logic [3:0] ST_CMP    = 4'd9;
    localparam logic [3:0] ST_SWEEP  = 4'd10;
    localparam logic [3:0] ST_FINISH = 4'd11;

    logic [CFG_W-1:0]  grid_width_reg, grid_height_reg;
    logic [SIDE_W-1:0] side_w, side_h;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              reply_reg, reply_next;
    logic              pend_reg, pend_next;
    logic [LBL_W-1:0]  pend_addr_reg, pend_addr_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_opened_reg, out_opened_next;
    logic              out_bad_reg, out_bad_next;

    logic [FUNC_W-1:0] func_reg, func_next;
    logic [WALL_W-1:0] idx_reg, idx_next;
    logic              res_opened_reg, res_opened_next;
    logic              res_bad_reg, res_bad_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [LBL_W-1:0]  cell_a_reg, cell_a_next;
    logic [LBL_W-1:0]  cell_b_reg, cell_b_next;
    logic [LBL_W-1:0]  la_reg, la_next;
    logic [LBL_W-1:0]  lb_reg, lb_next;

    logic [WALL_W-1:0] mul_a;
    logic [SIDE_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [LBL_W-1:0]  cell_a_calc;

    logic              div_start, div_done;
    logic [SIDE_W-1:0] div_divisor;
    logic [WALL_W-1:0] div_quot;
    logic [SIDE_W-1:0] div_rem;

    logic              mem_we;
    logic [LBL_W-1:0]  mem_waddr, mem_wdata, mem_raddr, mem_rdata;

    logic              accept;

    // Configuration registers keep their written bits; the clamp applies on use.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= CFG_W'(32);
            grid_height_reg <= CFG_W'(32);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (grid_width_reg < CFG_W'(2)) begin
            side_w = SIDE_W'(2);
        end else if (32'(grid_width_reg) > MAX_SIDE) begin
            side_w = SIDE_W'(MAX_SIDE);
        end else begin
            side_w = SIDE_W'(grid_width_reg);
        end
        if (grid_height_reg < CFG_W'(2)) begin
            side_h = SIDE_W'(2);
        end else if (32'(grid_height_reg) > MAX_SIDE) begin
            side_h = SIDE_W'(MAX_SIDE);
        end else begin
            side_h = SIDE_W'(grid_height_reg);
        end
    end

    // Shared multiplier: the wall count first, then row times width.
    always_comb begin
        if (state_reg == ST_BOUND) begin
            if (func_reg == FUNC_VWALL) begin
                mul_a = WALL_W'(side_h);
                mul_b = side_w - 1'b1;
            end else begin
                mul_a = WALL_W'(side_h - 1'b1);
                mul_b = side_w;
            end
        end else begin
            mul_a = div_quot;
            mul_b = side_w;
        end
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_divisor = (func_reg == FUNC_VWALL) ? side_w - 1'b1 : side_w;
    assign div_start   = (state_reg == ST_TEST) && (PROD_W'(idx_reg) < prod_reg);
    assign cell_a_calc = LBL_W'(prod_reg + PROD_W'(div_rem));

    gms_divider #(
        .DIV_W (SIDE_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (idx_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    gms_label_mem #(
        .DEPTH (CELL_COUNT),
        .AW    (LBL_W)
    ) u_label_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        reply_next      = reply_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        m_valid_next    = m_valid_reg;
        out_opened_next = out_opened_reg;
        out_bad_next    = out_bad_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        res_opened_next = res_opened_reg;
        res_bad_next    = res_bad_reg;
        prod_next       = prod_reg;
        cell_a_next     = cell_a_reg;
        cell_b_next     = cell_b_reg;
        la_next         = la_reg;
        lb_next         = lb_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[LBL_W-1:0];
        mem_wdata       = cnt_reg[LBL_W-1:0];
        mem_raddr       = cell_a_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CELL_COUNT - 1)) begin
                    state_next = reply_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    func_next       = s_tuser;
                    idx_next        = s_tdata[WALL_W-1:0];
                    res_opened_next = 1'b0;
                    res_bad_next    = 1'b0;
                    unique case (s_tuser)
                        FUNC_RESTART: begin
                            cnt_next   = '0;
                            reply_next = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        FUNC_VWALL, FUNC_HWALL: state_next = ST_BOUND;
                        FUNC_UNUSED:            state_next = ST_FINISH;
                        default:                state_next = ST_FINISH;
                    endcase
                end
            end
            ST_BOUND: begin
                prod_next  = mul_p;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (div_start) begin
                    state_next = ST_DIV;
                end else begin
                    res_bad_next = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = mul_p;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cell_a_next = cell_a_calc;
                if (func_reg == FUNC_VWALL) begin
                    cell_b_next = cell_a_calc + 1'b1;
                end else begin
                    cell_b_next = cell_a_calc + LBL_W'(side_w);
                end
                state_next = ST_RDA;
            end
            ST_RDA: begin
                mem_raddr  = cell_a_reg;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                mem_raddr  = cell_b_reg;
                la_next    = mem_rdata;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (mem_rdata == la_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    lb_next         = mem_rdata;
                    res_opened_next = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // Read one entry per cycle; rewrite it in the following cycle if it holds the old label.
                mem_raddr = cnt_reg[LBL_W-1:0];
                mem_we    = pend_reg && (mem_rdata == lb_reg);
                mem_waddr = pend_addr_reg;
                mem_wdata = la_reg;
                if (cnt_reg != CNT_W'(CELL_COUNT)) begin
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[LBL_W-1:0];
                    cnt_next       = cnt_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    out_opened_next = res_opened_reg;
                    out_bad_next    = res_bad_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            reply_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            reply_reg   <= reply_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        pend_addr_reg  <= pend_addr_next;
        out_opened_reg <= out_opened_next;
        out_bad_reg    <= out_bad_next;
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        res_opened_reg <= res_opened_next;
        res_bad_reg    <= res_bad_next;
        prod_reg       <= prod_next;
        cell_a_reg     <= cell_a_next;
        cell_b_reg     <= cell_b_next;
        la_reg         <= la_next;
        lb_reg         <= lb_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2){1'b0}}, out_bad_reg, out_opened_reg};

endmodule

### sv/gms_divider.sv
// ----------------------------------------------------------------------------
// gms_divider: restoring divider for wall index decode
// Splits a wall index into row and column, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gms_divider
    import gms_pkg::*;
#(
    parameter int DIV_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WALL_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [WALL_W-1:0] quotient,
    output logic [DIV_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(WALL_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WALL_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    // One subtract and compare per cycle; quotient bits shift in behind the dividend.
    assign trial = {rem_reg, dvd_reg[WALL_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DIV_W-1:0];
                dvd_next = {dvd_reg[WALL_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                dvd_next = {dvd_reg[WALL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WALL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

### sv/gms_label_mem.sv
// ----------------------------------------------------------------------------
// gms_label_mem: cell label store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gms_label_mem
    import gms_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [AW-1:0] rd_data
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
